@@ src/srsw_pkg.sv @@
// shared types, constants and sequence helpers for the selective repeat sender window
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  localparam int unsigned SeqCount = 20;
  localparam int unsigned SeqW     = 5;
  localparam int unsigned WinW     = 5;
  localparam int unsigned CountW   = 16;
  localparam int unsigned WireW    = 8;
  localparam int unsigned ActW     = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  localparam logic [WinW-1:0]   WindowReset = 5'd10;
  localparam logic [CountW-1:0] TotalReset  = 16'd25;

  localparam logic [CfgIdxW-1:0] CfgWindowSize   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTotalPackets = 1'd1;

  localparam logic [ActW-1:0] ActSend    = 2'd0;
  localparam logic [ActW-1:0] ActAck     = 2'd1;
  localparam logic [ActW-1:0] ActTimeout = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
    logic fix;
    logic load_out;
  } srsw_cmd_t;

  typedef struct packed {
    logic slide_start;
    logic slide_more;
    logic out_free;
  } srsw_status_t;

  function automatic logic [SeqW-1:0] seq_inc(input logic [SeqW-1:0] s);
    seq_inc = (s == SeqW'(SeqCount - 1)) ? '0 : s + SeqW'(1);
  endfunction

  function automatic logic [SeqW-1:0] seq_dist(input logic [SeqW-1:0] s,
                                               input logic [SeqW-1:0] b);
    logic [SeqW:0] t;
    t = {1'b0, s} + (SeqW+1)'(SeqCount) - {1'b0, b};
    if (t >= (SeqW+1)'(SeqCount)) begin
      t = t - (SeqW+1)'(SeqCount);
    end
    seq_dist = t[SeqW-1:0];
  endfunction

  function automatic logic [WinW-1:0] eff_window(input logic [WinW-1:0] w);
    if (w == '0) begin
      eff_window = WinW'(1);
    end else if (w >= WinW'(SeqCount - 1)) begin
      eff_window = WinW'(SeqCount - 1);
    end else begin
      eff_window = w;
    end
  endfunction

endpackage

`default_nettype wire

@@ src/selective_repeat_sender_window_unit.sv @@
// top level of the selective repeat sender window
`timescale 1ns / 1ps
`default_nettype none

// Sender window of a selective repeat ARQ over sequence numbers 0 to 19. Each request
// (send, acknowledgement or timeout) returns one result with the send decision and the
// window state after the request. A request is captured, then executed; an
// acknowledgement of the window base slides the base over the acknowledged flags
// one entry at a time before the result goes to the output register. A new request is
// taken while the previous result still waits in the output register. The user must
// issue configuration writes only while no request is in flight; it is not enforced.
module selective_repeat_sender_window_unit
  import srsw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // ack_wire_seq
  input  wire logic [ActW-1:0]     s_axis_tuser,  // action
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // send_valid, send_wire_seq, window_base, next_sequence, acks_seen, transfer_done
  output logic [OutDataW-1:0]      m_axis_tdata
);

  srsw_cmd_t    cmd;
  srsw_status_t status;

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srsw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (s_axis_tuser),
    .ack_wire_seq_i (s_axis_tdata),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ src/srsw_ctrl.sv @@
// control state machine sequencing capture, execute, slide and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl
  import srsw_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire srsw_status_t status_i,
  output srsw_cmd_t         cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StExec  = 2'd1;
  localparam logic [1:0] StSlide = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  always_comb begin
    in_ready_o = (state_q == StIdle) || (state_q == StOut && status_i.out_free);
    accept     = in_ready_o && in_valid_i;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.slide_start ? StSlide : StOut;
      end
      StSlide: begin
        if (status_i.slide_more) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.fix = 1'b1;
          state_d   = StOut;
        end
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (accept) begin
            cmd_o.capture = 1'b1;
            state_d       = StExec;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/srsw_dp.sv @@
// window state, acknowledged flags, configuration and output register
`timescale 1ns / 1ps
`default_nettype none

module srsw_dp
  import srsw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [ActW-1:0]     action_i,
  input  wire logic [WireW-1:0]    ack_wire_seq_i,
  input  wire srsw_cmd_t           cmd_i,
  output srsw_status_t             status_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o
);

  logic [WinW-1:0]     win_q;
  logic [CountW-1:0]   total_q;
  logic [ActW-1:0]     action_q;
  logic [WireW-1:0]    wire_q;
  logic [SeqCount-1:0] flags_q, flags_d;
  logic [SeqW-1:0]     base_q, base_d;
  logic [SeqW-1:0]     send_q, send_d;
  logic [CountW-1:0]   acks_q, acks_d;
  logic [SeqW-1:0]     n_q, n_d;
  logic [SeqW-1:0]     off_q, off_d;
  logic                sv_q, sv_d;
  logic [SeqW-1:0]     sw_q, sw_d;
  logic                start_q, start_d;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [WinW-1:0]  w;
  logic             done;
  logic [WireW-1:0] idx;
  logic             idx_ok;

  always_comb begin
    w      = eff_window(win_q);
    done   = acks_q >= total_q;
    idx    = wire_q - WireW'(1);
    idx_ok = (idx < WireW'(SeqCount)) && (seq_dist(idx[SeqW-1:0], base_q) < w);
  end

  always_comb begin
    flags_d = flags_q;
    base_d  = base_q;
    send_d  = send_q;
    acks_d  = acks_q;
    n_d     = n_q;
    off_d   = off_q;
    sv_d    = sv_q;
    sw_d    = sw_q;
    start_d = start_q;
    if (cmd_i.exec) begin
      sv_d    = 1'b0;
      sw_d    = '0;
      start_d = 1'b0;
      n_d     = '0;
      off_d   = seq_dist(send_q, base_q);
      case (action_q)
        ActSend: begin
          if (seq_dist(send_q, base_q) < w && !done) begin
            sv_d             = 1'b1;
            sw_d             = send_q + SeqW'(1);
            flags_d[send_q]  = 1'b0;
            send_d           = seq_inc(send_q);
          end
        end
        ActAck: begin
          if (idx_ok) begin
            if (acks_q != '1) begin
              acks_d = acks_q + CountW'(1);
            end
            flags_d[idx[SeqW-1:0]] = 1'b1;
            start_d                = (idx[SeqW-1:0] == base_q);
          end
        end
        ActTimeout: begin
          send_d = base_q;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.step) begin
      flags_d[base_q] = 1'b0;
      base_d          = seq_inc(base_q);
      n_d             = n_q + SeqW'(1);
    end
    if (cmd_i.fix && off_q < n_q) begin
      send_d = base_q;
    end
  end

  always_comb begin
    status_o.slide_start = start_d;
    status_o.slide_more  = (n_q < w) && flags_q[base_q];
    status_o.out_free    = !out_valid_q || out_ready_i;
    out_valid_o          = out_valid_q;
    out_data_o           = out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WindowReset;
      total_q     <= TotalReset;
      flags_q     <= '0;
      base_q      <= '0;
      send_q      <= '0;
      acks_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWindowSize:   win_q   <= cfg_data_i[WinW-1:0];
          CfgTotalPackets: total_q <= cfg_data_i[CountW-1:0];
          default: begin
          end
        endcase
      end
      flags_q     <= flags_d;
      base_q      <= base_d;
      send_q      <= send_d;
      acks_q      <= acks_d;
      out_valid_q <= cmd_i.load_out || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      wire_q   <= ack_wire_seq_i;
    end
    n_q     <= n_d;
    off_q   <= off_d;
    sv_q    <= sv_d;
    sw_q    <= sw_d;
    start_q <= start_d;
    if (cmd_i.load_out) begin
      out_data_q <= {7'd0, done, acks_q, send_q, base_q, sw_q, sv_q};
    end
  end

endmodule

`default_nettype wire
